// File: rtl/alpha_beta_gamma_tracker_top_macros.svh
// assertion macros for the alpha-beta-gamma tracker
// used by the controller; expects signals named clock and reset in scope
`ifndef ALPHA_BETA_GAMMA_TRACKER_TOP_MACROS_SVH
`define ALPHA_BETA_GAMMA_TRACKER_TOP_MACROS_SVH

// property that holds in the same cycle
`define ABGT_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// property checked in the cycle after the antecedent
`define ABGT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/abgt_pkg.sv
// shared types, constants and saturation helpers for the tracker
// used by abgt_ctrl, abgt_dpath and alpha_beta_gamma_tracker_top
`default_nettype none

package abgt_pkg;

   // register indexes of the csr port
   localparam logic [1:0] CSR_FILTER_ORDER = 2'd0;
   localparam logic [1:0] CSR_ALPHA_GAIN   = 2'd1;
   localparam logic [1:0] CSR_BETA_GAIN    = 2'd2;
   localparam logic [1:0] CSR_GAMMA_GAIN   = 2'd3;

   localparam int GAIN_W = 18;

   localparam logic             RST_FILTER_ORDER = 1'b1;
   localparam logic [GAIN_W-1:0] RST_ALPHA_GAIN  = 18'd32768;
   localparam logic [GAIN_W-1:0] RST_BETA_GAIN   = 18'd6554;
   localparam logic [GAIN_W-1:0] RST_GAMMA_GAIN  = 18'd655;

   // divider iteration counts minus one: 64 + shift bits
   localparam logic [6:0] DIV_CNT_T = 7'd63;
   localparam logic [6:0] DIV_CNT_D = 7'd80;

   // product scaling shifts
   localparam logic [5:0] SH_NONE = 6'd0;
   localparam logic [5:0] SH_Q16  = 6'd16;
   localparam logic [5:0] SH_ACC  = 6'd33;

   localparam logic [60:0]        QUO_LIM  = 61'h1000_0000_0000_0000;
   localparam logic signed [96:0] TERM_LIM = 97'sd1152921504606846976;
   localparam logic signed [63:0] RES_LIM  = 64'sd35184372088831;
   localparam logic signed [63:0] S32_MAX  = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN  = -64'sd2147483648;

   typedef struct packed {
      logic              filter_order;
      logic [GAIN_W-1:0] alpha_gain;
      logic [GAIN_W-1:0] beta_gain;
      logic [GAIN_W-1:0] gamma_gain;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_FIRST, OP_BAD, OP_MSET, OP_PP0, OP_PP1, OP_PP2,
      OP_MFIN, OP_APPLY, OP_RESID, OP_DSET, OP_DSTEP, OP_DFIN, OP_COMMIT, OP_OUT
   } dp_op_type;

   // which product is being formed
   typedef enum logic [2:0] {
      JOB_TT, JOB_VT, JOB_AD, JOB_AT, JOB_RA, JOB_RB, JOB_RG
   } job_type;

   typedef struct packed {
      dp_op_type op;
      job_type   job;
   } dp_cmd_type;

   typedef struct packed {
      logic t_zero;
   } dp_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] res;
      if (v > S32_MAX) res = 32'sh7FFF_FFFF;
      else if (v < S32_MIN) res = 32'sh8000_0000;
      else res = v[31:0];
      return res;
   endfunction

   function automatic logic signed [61:0] term_clamp(input logic signed [96:0] v);
      logic signed [61:0] res;
      if (v > TERM_LIM) res = 62'sh1000_0000_0000_0000;
      else if (v < -TERM_LIM) res = -62'sh1000_0000_0000_0000;
      else res = v[61:0];
      return res;
   endfunction

   function automatic logic signed [45:0] res_clamp(input logic signed [63:0] v);
      logic signed [45:0] res;
      if (v > RES_LIM) res = RES_LIM[45:0];
      else if (v < -RES_LIM) res = 46'(-RES_LIM);
      else res = v[45:0];
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/abgt_ctrl.sv
// tracker sequencer: handshakes, started flag and command stream to the datapath
// depends on abgt_pkg and alpha_beta_gamma_tracker_top_macros.svh
`default_nettype none
`include "alpha_beta_gamma_tracker_top_macros.svh"

module abgt_ctrl import abgt_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire logic          filter_order,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_MSET, S_PP0, S_PP1, S_PP2, S_DRAIN, S_MFIN,
      S_APPLY, S_RESID, S_DSET, S_DSTEP, S_DFIN, S_COMMIT, S_OUT
   } state_type;

   state_type  state_ff;
   job_type    job_ff;
   logic [6:0] cnt_ff;
   logic       started_ff;
   logic       rsp_valid_ff;
   logic       out_free;
   logic       req_acc;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd.job = job_ff;
      unique case (state_ff)
         S_IDLE:   cmd.op = req_acc ? OP_LOAD : OP_NONE;
         S_CHECK: begin
            if (!started_ff) cmd.op = OP_FIRST;
            else if (status.t_zero) cmd.op = OP_BAD;
            else cmd.op = OP_NONE;
         end
         S_MSET:   cmd.op = OP_MSET;
         S_PP0:    cmd.op = OP_PP0;
         S_PP1:    cmd.op = OP_PP1;
         S_PP2:    cmd.op = OP_PP2;
         S_DRAIN:  cmd.op = OP_NONE;
         S_MFIN:   cmd.op = OP_MFIN;
         S_APPLY:  cmd.op = OP_APPLY;
         S_RESID:  cmd.op = OP_RESID;
         S_DSET:   cmd.op = OP_DSET;
         S_DSTEP:  cmd.op = OP_DSTEP;
         S_DFIN:   cmd.op = OP_DFIN;
         S_COMMIT: cmd.op = OP_COMMIT;
         S_OUT:    cmd.op = out_free ? OP_OUT : OP_NONE;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= JOB_TT;
         cnt_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_OUT a new result replaces the one being taken
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_acc) state_ff <= S_CHECK;
            S_CHECK: begin
               if (!started_ff) begin
                  started_ff <= 1'b1;
                  state_ff   <= S_OUT;
               end else if (status.t_zero) begin
                  state_ff <= S_OUT;
               end else begin
                  job_ff   <= JOB_TT;
                  state_ff <= S_MSET;
               end
            end
            S_MSET:  state_ff <= S_PP0;
            S_PP0:   state_ff <= S_PP1;
            S_PP1:   state_ff <= S_PP2;
            S_PP2:   state_ff <= S_DRAIN;
            S_DRAIN: begin
               // gain products for the rate terms go on to the divider
               if (job_ff == JOB_RB || job_ff == JOB_RG) state_ff <= S_DSET;
               else state_ff <= S_MFIN;
            end
            S_MFIN:  state_ff <= S_APPLY;
            S_DSET: begin
               cnt_ff   <= (job_ff == JOB_RB) ? DIV_CNT_T : DIV_CNT_D;
               state_ff <= S_DSTEP;
            end
            S_DSTEP: begin
               if (cnt_ff == '0) state_ff <= S_DFIN;
               else cnt_ff <= cnt_ff - 7'd1;
            end
            S_DFIN:  state_ff <= S_APPLY;
            S_APPLY: begin
               unique case (job_ff)
                  JOB_TT: begin job_ff <= JOB_VT; state_ff <= S_MSET; end
                  JOB_VT: begin job_ff <= JOB_AD; state_ff <= S_MSET; end
                  JOB_AD: begin job_ff <= JOB_AT; state_ff <= S_MSET; end
                  JOB_AT: state_ff <= S_RESID;
                  JOB_RA: begin job_ff <= JOB_RB; state_ff <= S_MSET; end
                  JOB_RB: begin
                     if (filter_order) begin
                        job_ff   <= JOB_RG;
                        state_ff <= S_MSET;
                     end else begin
                        state_ff <= S_COMMIT;
                     end
                  end
                  JOB_RG:  state_ff <= S_COMMIT;
                  default: state_ff <= S_COMMIT;
               endcase
            end
            S_RESID: begin
               job_ff   <= JOB_RA;
               state_ff <= S_MSET;
            end
            S_COMMIT: state_ff <= S_OUT;
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ABGT_ASSERT_NEXT(a_busy_after_accept, req_acc, !req_tready,
      "input still ready after a transaction was taken")
   `ABGT_ASSERT(a_div_cnt_range, state_ff == S_DSTEP, cnt_ff <= DIV_CNT_D,
      "divider count out of range")
   `ABGT_ASSERT(a_commit_started, state_ff == S_COMMIT, started_ff,
      "update committed before the first sample")
   `ABGT_ASSERT_NEXT(a_out_loads, state_ff == S_OUT && out_free,
      rsp_valid_ff && state_ff == S_IDLE, "result not presented after output load")

endmodule

`default_nettype wire

// File: rtl/abgt_dpath.sv
// tracker datapath: state, shared 32x32 multiplier with accumulator, serial divider
// depends on abgt_pkg; driven by commands from abgt_ctrl
`default_nettype none

module abgt_dpath import abgt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_cmd_type  cmd,
   input  wire cfg_type     cfg,
   input  wire logic [63:0] req_data,
   output dp_status_type    status,
   output logic [95:0]      rsp_data,
   output logic [1:0]       rsp_user
);

   logic signed [31:0] z_ff, x_ff, v_ff, a_ff, xn_ff, vn_ff, an_ff;
   logic [31:0]        t_ff;
   logic [63:0]        d_ff;
   logic signed [63:0] xp_ff, vp_ff;
   logic signed [45:0] r_ff;
   logic [45:0]        mop_ff;
   logic [63:0]        uop_ff;
   logic               neg_ff;
   logic [5:0]         sh_ff;
   logic [63:0]        prod_ff;
   logic               prod_vld_ff;
   logic               prod_hi_ff;
   logic [95:0]        acc_ff;
   logic signed [61:0] term_ff;
   logic [63:0]        nsh_ff, rem_ff, den_ff;
   logic [60:0]        q_ff;
   logic               ovf_ff;
   logic               first_ff, bad_ff;
   logic [95:0]        rsp_data_ff;
   logic [1:0]         rsp_user_ff;

   logic signed [31:0] a_eff;
   logic [31:0]        a_mag, v_mag;
   logic [45:0]        r_mag;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        prod_in;
   logic signed [96:0] acc_s, acc_sh;
   logic signed [61:0] mterm_in, dterm_in;
   logic [63:0]        rsh;
   logic               ge;
   logic [63:0]        rem_in;
   logic [61:0]        qn;
   logic [61:0]        qup;
   logic [60:0]        qf;
   logic               round_up;

   assign a_eff = cfg.filter_order ? a_ff : 32'sd0;
   assign a_mag = a_eff[31] ? 32'(-a_eff) : a_eff;
   assign v_mag = v_ff[31] ? 32'(-v_ff) : v_ff;
   assign r_mag = r_ff[45] ? 46'(-r_ff) : r_ff;

   assign status.t_zero = (t_ff == '0);

   // partial products: low x low, high x low, low x high
   always_comb begin
      unique case (cmd.op)
         OP_PP0: begin
            mul_a = mop_ff[31:0];
            mul_b = uop_ff[31:0];
         end
         OP_PP1: begin
            mul_a = 32'(mop_ff[45:32]);
            mul_b = uop_ff[31:0];
         end
         OP_PP2: begin
            mul_a = mop_ff[31:0];
            mul_b = uop_ff[63:32];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod_in = mul_a * mul_b;

   // signed, scaled and limited product term
   assign acc_s    = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
   assign acc_sh   = acc_s >>> sh_ff;
   assign mterm_in = term_clamp(acc_sh);

   // restoring divide step
   assign rsh    = {rem_ff[62:0], nsh_ff[63]};
   assign ge     = rem_ff[63] || (rsh >= den_ff);
   assign rem_in = ge ? rsh - den_ff : rsh;
   assign qn     = {q_ff, ge};

   // negative quotients round away from zero so the result is a floor
   assign round_up = neg_ff && (rem_ff != '0);
   assign qup      = {1'b0, q_ff} + 62'(round_up);
   assign qf       = (ovf_ff || qup > 62'(QUO_LIM)) ? QUO_LIM : qup[60:0];
   assign dterm_in = neg_ff ? -$signed({1'b0, qf}) : $signed({1'b0, qf});

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= (cmd.op == OP_PP0) || (cmd.op == OP_PP1) || (cmd.op == OP_PP2);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      prod_hi_ff <= (cmd.op == OP_PP1) || (cmd.op == OP_PP2);
      if (cmd.op == OP_MSET) acc_ff <= '0;
      else if (prod_vld_ff) begin
         acc_ff <= acc_ff + (prod_hi_ff ? {prod_ff, 32'b0} : {32'b0, prod_ff});
      end

      unique case (cmd.op)
         OP_LOAD: begin
            z_ff <= req_data[31:0];
            t_ff <= req_data[63:32];
         end
         OP_FIRST: begin
            x_ff     <= z_ff;
            v_ff     <= '0;
            a_ff     <= '0;
            first_ff <= 1'b1;
            bad_ff   <= 1'b0;
         end
         OP_BAD: begin
            first_ff <= 1'b0;
            bad_ff   <= 1'b1;
         end
         OP_MSET: begin
            unique case (cmd.job)
               JOB_TT: begin
                  mop_ff <= 46'(t_ff); uop_ff <= 64'(t_ff);
                  neg_ff <= 1'b0;      sh_ff  <= SH_NONE;
               end
               JOB_VT: begin
                  mop_ff <= 46'(v_mag); uop_ff <= 64'(t_ff);
                  neg_ff <= v_ff[31];   sh_ff  <= SH_Q16;
               end
               JOB_AD: begin
                  mop_ff <= 46'(a_mag); uop_ff <= d_ff;
                  neg_ff <= a_eff[31];  sh_ff  <= SH_ACC;
               end
               JOB_AT: begin
                  mop_ff <= 46'(a_mag); uop_ff <= 64'(t_ff);
                  neg_ff <= a_eff[31];  sh_ff  <= SH_Q16;
               end
               JOB_RA: begin
                  mop_ff <= r_mag;     uop_ff <= 64'(cfg.alpha_gain);
                  neg_ff <= r_ff[45];  sh_ff  <= SH_Q16;
               end
               JOB_RB: begin
                  mop_ff <= r_mag;     uop_ff <= 64'(cfg.beta_gain);
                  neg_ff <= r_ff[45];  sh_ff  <= SH_NONE;
               end
               JOB_RG: begin
                  mop_ff <= r_mag;     uop_ff <= 64'(cfg.gamma_gain);
                  neg_ff <= r_ff[45];  sh_ff  <= SH_NONE;
               end
               default: begin
                  mop_ff <= '0;   uop_ff <= '0;
                  neg_ff <= 1'b0; sh_ff  <= SH_NONE;
               end
            endcase
         end
         OP_MFIN: term_ff <= mterm_in;
         OP_DSET: begin
            nsh_ff <= {1'b0, acc_ff[62:0]};
            rem_ff <= '0;
            q_ff   <= '0;
            ovf_ff <= 1'b0;
            den_ff <= (cmd.job == JOB_RB) ? 64'(t_ff) : d_ff;
         end
         OP_DSTEP: begin
            nsh_ff <= {nsh_ff[62:0], 1'b0};
            rem_ff <= rem_in;
            q_ff   <= qn[60:0];
            ovf_ff <= ovf_ff || (qn > 62'(QUO_LIM));
         end
         OP_DFIN: term_ff <= dterm_in;
         OP_APPLY: begin
            unique case (cmd.job)
               JOB_TT:  d_ff  <= acc_ff[63:0];
               JOB_VT:  xp_ff <= 64'(x_ff) + 64'(term_ff);
               JOB_AD:  xp_ff <= xp_ff + 64'(term_ff);
               JOB_AT:  vp_ff <= 64'(v_ff) + 64'(term_ff);
               JOB_RA:  xn_ff <= sat32(xp_ff + 64'(term_ff));
               JOB_RB:  vn_ff <= sat32(vp_ff + 64'(term_ff));
               JOB_RG:  an_ff <= sat32(64'(a_eff) + 64'(term_ff));
               default: d_ff  <= d_ff;
            endcase
         end
         OP_RESID: r_ff <= res_clamp(64'(z_ff) - xp_ff);
         OP_COMMIT: begin
            x_ff     <= xn_ff;
            v_ff     <= vn_ff;
            a_ff     <= cfg.filter_order ? an_ff : 32'sd0;
            first_ff <= 1'b0;
            bad_ff   <= 1'b0;
         end
         OP_OUT: begin
            rsp_data_ff <= {a_eff, v_ff, x_ff};
            rsp_user_ff <= {bad_ff, first_ff};
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = rsp_data_ff;
   assign rsp_user = rsp_user_ff;

endmodule

`default_nettype wire

// File: rtl/alpha_beta_gamma_tracker_top.sv
// Alpha-beta-gamma position tracker, one result transaction per measurement.
// An update takes longer in alpha-beta-gamma mode than in alpha-beta mode; the
// time is set by the bit-serial divider (beta/dt and 2*gamma/dt^2) and the
// shared 32x32 multiplier, which the first sample and a zero interval skip.
// One measurement is in work at a time; a finished result waits in the output
// register while the next measurement is taken. Gains may be changed only while
// the block is idle.
// depends on abgt_pkg, abgt_ctrl and abgt_dpath
`default_nettype none

module alpha_beta_gamma_tracker_top import abgt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // measured_position, sample_interval
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,  // position_estimate, velocity_estimate,
                                        // acceleration_estimate
   output logic [1:0]       rsp_tuser,  // first_sample, bad_interval
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [17:0] csr_wdata
);

   cfg_type       cfg_ff;
   dp_cmd_type    cmd;
   dp_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_order <= RST_FILTER_ORDER;
         cfg_ff.alpha_gain   <= RST_ALPHA_GAIN;
         cfg_ff.beta_gain    <= RST_BETA_GAIN;
         cfg_ff.gamma_gain   <= RST_GAMMA_GAIN;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FILTER_ORDER: cfg_ff.filter_order <= csr_wdata[0];
            CSR_ALPHA_GAIN:   cfg_ff.alpha_gain   <= csr_wdata;
            CSR_BETA_GAIN:    cfg_ff.beta_gain    <= csr_wdata;
            CSR_GAMMA_GAIN:   cfg_ff.gamma_gain   <= csr_wdata;
            default:          cfg_ff              <= cfg_ff;
         endcase
      end
   end

   abgt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .filter_order (cfg_ff.filter_order),
      .status       (status),
      .cmd          (cmd)
   );

   abgt_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg_ff),
      .req_data (req_tdata),
      .status   (status),
      .rsp_data (rsp_tdata),
      .rsp_user (rsp_tuser)
   );

endmodule

`default_nettype wire
